// ===== design/rfs_pkg.sv =====
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared types and constants of the rgb fade stepper: level and step widths,
// register indexes, sequencer states and the divider and tile structs.
// ----------------------------------------------------------------------------
package rfs_pkg;

  localparam int unsigned LEVEL_W   = 9;
  localparam int unsigned STEPS_W   = 12;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned CHAN_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 12;

  localparam logic [LEVEL_W-1:0] NEUTRAL_LEVEL = 9'h100;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BLUE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEPS   = 2'd3;

  localparam logic [CHAN_W-1:0] CHAN_RED  = 2'd0;
  localparam logic [CHAN_W-1:0] CHAN_BLUE = 2'd2;

  typedef logic [NUM_CHAN-1:0][LEVEL_W-1:0] level_arr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] dividend;
    logic [STEPS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              draw_overlay;
    logic              blend_subtract;
    logic [BYTE_W-1:0] tile_red;
    logic [BYTE_W-1:0] tile_green;
    logic [BYTE_W-1:0] tile_blue;
  } tile_t;

endpackage

// ===== design/rfs_tick_if.sv =====
// ----------------------------------------------------------------------------
// rfs_tick_if
// Frame tick channel: valid/ready handshake carrying the frame tick bit.
// ----------------------------------------------------------------------------
interface rfs_tick_if;
  logic valid;
  logic ready;
  logic frame_tick;

  modport source (output valid, output frame_tick, input ready);
  modport sink   (input valid, input frame_tick, output ready);
endinterface

// ===== design/rfs_result_if.sv =====
// ----------------------------------------------------------------------------
// rfs_result_if
// Result channel: valid/ready handshake carrying overlay tile and levels.
// ----------------------------------------------------------------------------
interface rfs_result_if;
  logic       valid;
  logic       ready;
  logic       draw_overlay;
  logic       blend_subtract;
  logic [7:0] tile_red;
  logic [7:0] tile_green;
  logic [7:0] tile_blue;
  logic [8:0] level_red;
  logic [8:0] level_green;
  logic [8:0] level_blue;

  modport source (
    output valid, output draw_overlay, output blend_subtract,
    output tile_red, output tile_green, output tile_blue,
    output level_red, output level_green, output level_blue,
    input  ready
  );
  modport sink (
    input  valid, input draw_overlay, input blend_subtract,
    input  tile_red, input tile_green, input tile_blue,
    input  level_red, input level_green, input level_blue,
    output ready
  );
endinterface

// ===== design/rfs_serial_div.sv =====
// ----------------------------------------------------------------------------
// rfs_serial_div
// Bit-serial restoring divider: unsigned level magnitude by step count,
// one quotient bit per cycle, shared by the three color channels.
// ----------------------------------------------------------------------------
module rfs_serial_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfs_pkg::div_req_t req_i,
  output rfs_pkg::div_rsp_t rsp_o
);
  import rfs_pkg::*;

  localparam int unsigned CNT_W = $clog2(LEVEL_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LEVEL_W - 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [STEPS_W-1:0] rem_q, rem_d;
  logic [LEVEL_W-1:0] quo_q, quo_d;
  logic [STEPS_W-1:0] div_q, div_d;
  logic [STEPS_W:0]   trial;
  logic               fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[LEVEL_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? STEPS_W'(trial - {1'b0, div_q}) : trial[STEPS_W-1:0];
      quo_d = {quo_q[LEVEL_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== design/rfs_tile_fmt.sv =====
// ----------------------------------------------------------------------------
// rfs_tile_fmt
// Overlay tile formatting: picks additive or subtractive blend from red and
// derives the tile color bytes from the current levels.
// ----------------------------------------------------------------------------
module rfs_tile_fmt (
  input  rfs_pkg::level_arr_t level_i,
  output rfs_pkg::tile_t      tile_o
);
  import rfs_pkg::*;

  logic                           overlay;
  logic                           additive;
  logic [NUM_CHAN-1:0][BYTE_W-1:0] tile_byte;
  logic [LEVEL_W-1:0]             dec;

  always_comb begin
    overlay  = !(level_i[0] == NEUTRAL_LEVEL && level_i[1] == NEUTRAL_LEVEL &&
                 level_i[2] == NEUTRAL_LEVEL);
    additive = level_i[CHAN_RED] > NEUTRAL_LEVEL;
    dec      = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      dec = level_i[c] - 1'b1;
      if (!overlay) begin
        tile_byte[c] = '0;
      end else if (additive) begin
        tile_byte[c] = dec[BYTE_W-1:0];
      end else if (level_i[c] == NEUTRAL_LEVEL) begin
        tile_byte[c] = '0;
      end else begin
        tile_byte[c] = ~level_i[c][BYTE_W-1:0];
      end
    end
    tile_o.draw_overlay   = overlay;
    tile_o.blend_subtract = overlay && !additive;
    tile_o.tile_red       = tile_byte[0];
    tile_o.tile_green     = tile_byte[1];
    tile_o.tile_blue      = tile_byte[2];
  end

endmodule

// ===== design/rgb_fade_stepper_core.sv =====
// ----------------------------------------------------------------------------
// rgb_fade_stepper_core
// Per-frame screen fade engine with a shared bit-serial divider.
// ----------------------------------------------------------------------------
// Each accepted frame tick moves the red, green and blue levels toward their
// targets by (target - current) / steps_left, truncated toward zero, then
// returns one result with the overlay tile and the new levels. For a tick with
// steps remaining, the three channels go one after the other through a single
// restoring divider that yields one quotient bit per cycle (9 bits per channel,
// each after a load state and followed by the level update); then the result
// is loaded into the output register. A tick with no steps left, or with
// frame_tick low, skips the divider and goes straight to the result load.
// The next tick is taken once the result sits in the output register, even
// if not yet taken; while a previous result still waits there, the sequencer
// holds before loading the new one. Writing fade_steps reloads the countdown;
// configure only while idle.
// ----------------------------------------------------------------------------
module rgb_fade_stepper_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rfs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rfs_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  rfs_tick_if.sink                           tick_i,
  rfs_result_if.source                       result_o
);
  import rfs_pkg::*;

  state_e             state_q, state_d;
  logic [CHAN_W-1:0]  ch_q, ch_d;
  level_arr_t         cur_q, cur_d;
  level_arr_t         tgt_q, tgt_d;
  logic [STEPS_W-1:0] steps_q, steps_d;

  logic               out_valid_q, out_valid_d;
  tile_t              out_tile_q, out_tile_d;
  level_arr_t         out_level_q, out_level_d;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  tile_t              tile;

  logic               in_ready;
  logic               in_fire;
  logic               out_load;
  logic               neg;
  logic [LEVEL_W:0]   diff;
  logic [LEVEL_W-1:0] mag;

  // signed difference of the channel in work, 10 bits
  assign diff = {1'b0, tgt_q[ch_q]} - {1'b0, cur_q[ch_q]};
  assign neg  = diff[LEVEL_W];
  assign mag  = neg ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];

  rfs_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rfs_tile_fmt u_fmt (
    .level_i (cur_q),
    .tile_o  (tile)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (tick_i.frame_tick && steps_q != '0) ? S_LOAD : S_DONE;
        end
      end
      S_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = (ch_q == CHAN_BLUE) ? S_DONE : S_LOAD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready         = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = mag;
    div_req.divisor  = steps_q;
    unique case (state_q)
      S_IDLE: in_ready = 1'b1;
      S_LOAD: div_req.start = 1'b1;
      S_DIV:  ;
      S_DONE: out_load = !out_valid_q || result_o.ready;
      default: ;
    endcase
  end

  assign in_fire = tick_i.valid && in_ready;

  // datapath and configuration
  always_comb begin
    ch_d    = ch_q;
    cur_d   = cur_q;
    tgt_d   = tgt_q;
    steps_d = steps_q;
    if (in_fire) begin
      ch_d = CHAN_RED;
      if (tick_i.frame_tick && steps_q == '0) begin
        cur_d = tgt_q;
      end
    end
    if (state_q == S_DIV && div_rsp.done) begin
      cur_d[ch_q] = neg ? cur_q[ch_q] - div_rsp.quotient
                        : cur_q[ch_q] + div_rsp.quotient;
      ch_d        = ch_q + 1'b1;
      if (ch_q == CHAN_BLUE) begin
        steps_d = steps_q - 1'b1;
      end
    end
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_RED:   tgt_d[0] = cfg_data_i[LEVEL_W-1:0];
        REG_TARGET_GREEN: tgt_d[1] = cfg_data_i[LEVEL_W-1:0];
        REG_TARGET_BLUE:  tgt_d[2] = cfg_data_i[LEVEL_W-1:0];
        REG_FADE_STEPS:   steps_d  = cfg_data_i[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_tile_d  = out_tile_q;
    out_level_d = out_level_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_tile_d  = tile;
      out_level_d = cur_q;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= CHAN_RED;
      cur_q       <= {NUM_CHAN{NEUTRAL_LEVEL}};
      tgt_q       <= {NUM_CHAN{NEUTRAL_LEVEL}};
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      cur_q       <= cur_d;
      tgt_q       <= tgt_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_tile_q  <= out_tile_d;
    out_level_q <= out_level_d;
  end

  assign tick_i.ready            = in_ready;
  assign result_o.valid          = out_valid_q;
  assign result_o.draw_overlay   = out_tile_q.draw_overlay;
  assign result_o.blend_subtract = out_tile_q.blend_subtract;
  assign result_o.tile_red       = out_tile_q.tile_red;
  assign result_o.tile_green     = out_tile_q.tile_green;
  assign result_o.tile_blue      = out_tile_q.tile_blue;
  assign result_o.level_red      = out_level_q[0];
  assign result_o.level_green    = out_level_q[1];
  assign result_o.level_blue     = out_level_q[2];

  // divider finishes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider done outside of division state");

  // a channel in work is always one of the three
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD || state_q == S_DIV) |-> ch_q <= CHAN_BLUE)
    else $error("channel index out of range during division");

  // countdown drops by exactly one at the end of a fading tick
  a_step_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_rsp.done && ch_q == CHAN_BLUE && !cfg_we_i)
      |=> steps_q == $past(steps_q) - 1'b1)
    else $error("step countdown not decremented by one");

  // a fading tick never starts with an empty countdown
  a_no_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> steps_q != '0)
    else $error("division started with zero step count");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rgb_fade_stepper_core: frame ticks go in over the
// tick channel, and every returned result is compared field by field against
// a fade predictor that tracks the levels, targets and countdown. The bench
// runs reset-state ticks, directed blend and division cases first, then random
// fade phases, with bursty ticks and a stalling result receiver.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rfs_pkg::*;

  localparam int RANDOM_TICKS   = 1330;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic                            overlay;
    logic                            subtract;
    logic [NUM_CHAN-1:0][BYTE_W-1:0] tile;
    logic [NUM_CHAN-1:0][LEVEL_W-1:0] lvl;
  } frame_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_data;

  rfs_tick_if   tick_if ();
  rfs_result_if res_if ();

  rgb_fade_stepper_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .tick_i     (tick_if),
    .result_o   (res_if)
  );

  // fade predictor state
  logic [LEVEL_W-1:0] level_now  [NUM_CHAN];
  logic [LEVEL_W-1:0] target_lvl [NUM_CHAN];
  logic [STEPS_W-1:0] steps_left;

  frame_result_t expected_frames [$];

  int mismatch_count = 0;
  int ticks_sent     = 0;
  int ticks_low      = 0;
  int reg_writes     = 0;
  int results_seen   = 0;
  int fade_phases    = 0;
  int burst_left     = 0;

  string chan_name [NUM_CHAN] = '{"red", "green", "blue"};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("FAIL rgb_fade_stepper_core");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end else if (mismatch_count == MAX_PRINTED + 1) begin
      $display("further mismatches counted but not shown");
    end
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  // register write as the block sees it
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_TARGET_RED:   target_lvl[0] = data[LEVEL_W-1:0];
      REG_TARGET_GREEN: target_lvl[1] = data[LEVEL_W-1:0];
      REG_TARGET_BLUE:  target_lvl[2] = data[LEVEL_W-1:0];
      REG_FADE_STEPS:   steps_left = data[STEPS_W-1:0];
      default: ;
    endcase
  endfunction

  // one frame: move the levels, then build the overlay tile
  function automatic frame_result_t advance_fade(input logic tick);
    frame_result_t r;
    int            diff;
    logic          additive;
    r = '0;
    if (tick) begin
      if (steps_left != '0) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
          diff = int'(target_lvl[c]) - int'(level_now[c]);
          level_now[c] = LEVEL_W'(int'(level_now[c]) + diff / int'(steps_left));
        end
        steps_left = steps_left - 1'b1;
      end else begin
        level_now = target_lvl;
      end
    end
    r.overlay = !(level_now[0] == NEUTRAL_LEVEL && level_now[1] == NEUTRAL_LEVEL &&
                  level_now[2] == NEUTRAL_LEVEL);
    additive = level_now[0] > NEUTRAL_LEVEL;
    for (int c = 0; c < NUM_CHAN; c++) begin
      r.lvl[c] = level_now[c];
      if (r.overlay) begin
        if (additive) begin
          r.tile[c] = BYTE_W'(level_now[c] - 1'b1);
        end else begin
          r.tile[c] = (level_now[c] == NEUTRAL_LEVEL) ? '0 : ~level_now[c][BYTE_W-1:0];
        end
      end
    end
    r.subtract = r.overlay && !additive;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    frame_result_t want;
    frame_result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      got.overlay  = res_if.draw_overlay;
      got.subtract = res_if.blend_subtract;
      got.tile     = {res_if.tile_blue, res_if.tile_green, res_if.tile_red};
      got.lvl      = {res_if.level_blue, res_if.level_green, res_if.level_red};
      if (expected_frames.size() == 0) begin
        report_mismatch("result transaction with no tick outstanding");
      end else begin
        want = expected_frames.pop_front();
        check_field("draw_overlay", got.overlay, want.overlay);
        check_field("blend_subtract", got.subtract, want.subtract);
        for (int c = 0; c < NUM_CHAN; c++) begin
          check_field({"tile_", chan_name[c]}, got.tile[c], want.tile[c]);
          check_field({"level_", chan_name[c]}, got.lvl[c], want.lvl[c]);
        end
      end
    end
  end

  // receiver: stretches of differing stall density, some with none at all
  initial begin
    int stretch;
    int stall_pct;
    res_if.ready = 1'b0;
    forever begin
      stretch = $urandom_range(10, 120);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      repeat (stretch) begin
        @(negedge clk_i);
        res_if.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // sender works in bursts; valid stays up between items of one burst
  task automatic send_tick(input logic tick);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 45);
      if (gap > 0) begin
        tick_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    tick_if.valid      = 1'b1;
    tick_if.frame_tick = tick;
    do @(posedge clk_i); while (!tick_if.ready);
    burst_left--;
    ticks_sent++;
    if (!tick) ticks_low++;
    expected_frames.push_back(advance_fade(tick));
  endtask

  // hold off new ticks until every outstanding result is back
  task automatic drain_results();
    @(negedge clk_i);
    tick_if.valid = 1'b0;
    burst_left    = 0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(posedge clk_i);
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic set_fade(input logic [CFG_DAT_W-1:0] red, input logic [CFG_DAT_W-1:0] green,
                          input logic [CFG_DAT_W-1:0] blue, input logic [CFG_DAT_W-1:0] steps);
    drain_results();
    write_reg(REG_TARGET_RED, red);
    write_reg(REG_TARGET_GREEN, green);
    write_reg(REG_TARGET_BLUE, blue);
    write_reg(REG_FADE_STEPS, steps);
  endtask

  task automatic test_reset_state();
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // steps of zero jump straight to the target: additive, subtractive, edges
  task automatic test_blend_modes();
    set_fade(12'd511, 12'd0, 12'd256, 12'd0);
    send_tick(1'b1);
    set_fade(12'd257, 12'd256, 12'd0, 12'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    set_fade(12'd256, 12'd0, 12'd511, 12'd0);
    send_tick(1'b1);
    set_fade(12'd0, 12'd256, 12'd255, 12'd0);
    send_tick(1'b1);
    // upper data bits must be dropped on target writes
    set_fade(12'hF00, 12'hFFF, 12'hE01, 12'd0);
    send_tick(1'b1);
    set_fade(12'd256, 12'd256, 12'd256, 12'd0);
    send_tick(1'b1);
  endtask

  // one-step jump, the longest countdown and negative truncation
  task automatic test_step_division();
    set_fade(12'd0, 12'd511, 12'd256, 12'd1);
    send_tick(1'b1);
    set_fade(12'd511, 12'd0, 12'd100, 12'hFFF);
    repeat (3) send_tick(1'b1);
    set_fade(12'd256, 12'd256, 12'd0, 12'd3);
    repeat (4) send_tick(1'b1);
    set_fade(12'd2, 12'd509, 12'd0, 12'd7);
    repeat (3) send_tick(1'b1);
  endtask

  function automatic logic [CFG_DAT_W-1:0] pick_level_data();
    logic [2:0]         upper;
    logic [LEVEL_W-1:0] lvl;
    upper = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 7))
      0:       lvl = 9'd0;
      1:       lvl = 9'd511;
      2:       lvl = NEUTRAL_LEVEL;
      3:       lvl = NEUTRAL_LEVEL + 9'd1;
      4:       lvl = NEUTRAL_LEVEL - 9'd1;
      default: lvl = LEVEL_W'($urandom_range(0, 511));
    endcase
    return {upper, lvl};
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_steps();
    case ($urandom_range(0, 9))
      0:       return CFG_DAT_W'($urandom_range(0, 4095));
      1:       return 12'hFFF;
      2, 3:    return CFG_DAT_W'($urandom_range(21, 200));
      default: return CFG_DAT_W'($urandom_range(0, 20));
    endcase
  endfunction

  task automatic test_random_fades();
    int start_count;
    int n;
    start_count = ticks_sent;
    while (ticks_sent - start_count < RANDOM_TICKS) begin
      drain_results();
      fade_phases++;
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) != 0) write_reg(REG_TARGET_RED, pick_level_data());
        if ($urandom_range(0, 3) != 0) write_reg(REG_TARGET_GREEN, pick_level_data());
        if ($urandom_range(0, 3) != 0) write_reg(REG_TARGET_BLUE, pick_level_data());
        if ($urandom_range(0, 4) != 0) write_reg(REG_FADE_STEPS, pick_steps());
      end
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(0, 60) == 0) drain_results();
        send_tick($urandom_range(0, 9) != 0);
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_TARGET_RED;
    cfg_data           = '0;
    tick_if.valid      = 1'b0;
    tick_if.frame_tick = 1'b0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      level_now[c]  = NEUTRAL_LEVEL;
      target_lvl[c] = NEUTRAL_LEVEL;
    end
    steps_left = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_blend_modes();
    test_step_division();
    test_random_fades();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_frames.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_frames.size()));
    end

    $display("sent %0d frame ticks (%0d with tick low) over %0d random fade phases",
             ticks_sent, ticks_low, fade_phases);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             reg_writes, results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS rgb_fade_stepper_core");
    end else begin
      $display("FAIL rgb_fade_stepper_core");
    end
    $finish;
  end

endmodule
